/* hw/rtl/sfmt_pkg.sv */
`default_nettype none
// Shared constants, types and the lane recurrence of the SFMT19937 generator.
// Used by sfmt_store and sfmt_bounded_random_generator_core.
package sfmt_pkg;

  localparam int unsigned Lanes    = 156;
  localparam int unsigned Words    = 624;
  localparam int unsigned Pos1     = 122;
  localparam int unsigned LaneW    = 8;
  localparam int unsigned PosW     = 10;
  localparam logic [31:0] Mult     = 32'd1812433253;
  localparam logic [31:0] Parity3  = 32'h13c9e684;
  localparam logic [31:0] Mask0    = 32'hdfffffef;
  localparam logic [31:0] Mask1    = 32'hddfecb7f;
  localparam logic [31:0] Mask2    = 32'hbffaffff;
  localparam logic [31:0] Mask3    = 32'hbffffff6;
  localparam logic [31:0] Half     = 32'h8000_0000;
  localparam logic [31:0] NormTop  = 32'h4000_0000;

  localparam logic [1:0] KindSeed  = 2'd0;
  localparam logic [1:0] KindWord  = 2'd1;
  localparam logic [1:0] KindBound = 2'd2;

  typedef struct packed {
    logic [3:0]       en;
    logic [LaneW-1:0] addr;
    logic [127:0]     data;
  } sfmt_wr_t;

  function automatic logic [127:0] sfmt_recur(input logic [127:0] a, input logic [127:0] b,
                                              input logic [127:0] c, input logic [127:0] d);
    logic [127:0] bs;
    logic [127:0] ds;
    bs = {(b[127:96] >> 11) & Mask3, (b[95:64] >> 11) & Mask2,
          (b[63:32] >> 11) & Mask1, (b[31:0] >> 11) & Mask0};
    ds = {d[127:96] << 18, d[95:64] << 18, d[63:32] << 18, d[31:0] << 18};
    return a ^ (a << 8) ^ bs ^ (c >> 8) ^ ds;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/sfmt_store.sv */
`default_nettype none
// State store: four 32-bit banks of 156 lanes, one shared write address with
// per-bank enables and two registered read ports. Depends on sfmt_pkg.
module sfmt_store (
  input  wire logic                      clk_i,
  input  wire sfmt_pkg::sfmt_wr_t        wr_i,
  input  wire logic [sfmt_pkg::LaneW-1:0] ra_i,
  input  wire logic [sfmt_pkg::LaneW-1:0] rb_i,
  output logic [127:0]                   rda_o,
  output logic [127:0]                   rdb_o
);
  import sfmt_pkg::*;

  logic [31:0] mem_q [4][Lanes];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (wr_i.en[k]) begin
        mem_q[k][wr_i.addr] <= wr_i.data[32*k +: 32];
      end
      rda_o[32*k +: 32] <= mem_q[k][ra_i];
      rdb_o[32*k +: 32] <= mem_q[k][rb_i];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sfmt_bounded_random_generator_core.sv */
`default_nettype none
// Top level of the SFMT19937 bounded random generator: sequencer, seeding
// multiplier, lane recurrence and rejection draw. Depends on sfmt_pkg, sfmt_store.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one request: kind 0 seeds,
//   kind 1 returns the next raw word, kind 2 a value in [0,range) or 0 if range<=0.
//   Kind 3 is dropped. Output channel (out_valid_o / out_stall_i) carries the
//   value of kind 1 and kind 2 requests; seeds give no result.
//   One request is worked at a time; in_stall_o is high while it runs.
//   Seeding runs the multiply-add recurrence, with a multiply state and an
//   add-and-write state per word. A raw word is read from the store and
//   registered for output; once every 624 words the 156 lanes are first
//   regenerated, a read and a write state per lane. A bounded request first
//   normalizes a new range by doubling it; each compare step may halve the
//   base, and each rejection fetches a fresh word.
//   A draw before any seed first seeds from cfg default_seed.
//   The finished result waits in an output register; a new request is taken
//   while the receiver stalls, and its result holds until the slot frees.
//   Reset clears control state; default_seed resets to 5489. The store is
//   not cleared and is only read after a seed has written it.
module sfmt_bounded_random_generator_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  in_kind_i,
  input  wire logic [31:0] in_seed_value_i,
  input  wire logic signed [31:0] in_range_limit_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      out_value_o
);
  import sfmt_pkg::*;

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StSeedMul = 4'd1;
  localparam logic [3:0] StSeedAdd = 4'd2;
  localparam logic [3:0] StWord    = 4'd3;
  localparam logic [3:0] StRegInit = 4'd4;
  localparam logic [3:0] StRegLoad = 4'd5;
  localparam logic [3:0] StRegRd   = 4'd6;
  localparam logic [3:0] StRegWr   = 4'd7;
  localparam logic [3:0] StFetRd   = 4'd8;
  localparam logic [3:0] StFetUse  = 4'd9;
  localparam logic [3:0] StNorm    = 4'd10;
  localparam logic [3:0] StBdChk   = 4'd11;
  localparam logic [3:0] StBdLoop  = 4'd12;
  localparam logic [3:0] StBdShr   = 4'd13;
  localparam logic [3:0] StEmit    = 4'd14;

  logic [3:0]       state_q, state_d;
  logic [31:0]      dseed_q;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  p_q, p_d;
  logic [31:0]      s_q, s_d, w0_q, w0_d, prod_q, prod_d;
  logic             pend_q, pend_d;
  logic [1:0]       kind_q, kind_d;
  logic [31:0]      crange_q, crange_d, cbase_q, cbase_d;
  logic [4:0]       cshift_q, cshift_d;
  logic [31:0]      y_q, y_d, b_q, b_d, rem_q, rem_d, res_q, res_d;
  logic [4:0]       sh_q, sh_d;
  logic [LaneW-1:0] lane_q, lane_d;
  logic [127:0]     c_q, c_d, dl_q, dl_d;
  logic             ov_q, ov_d;
  logic [31:0]      ovalue_q, ovalue_d;

  sfmt_wr_t         wr;
  logic [LaneW-1:0] ra, rb;
  logic [127:0]     rda, rdb, rlane;
  logic [31:0]      s_new, word;
  logic             accept, inner;

  sfmt_store u_store (
    .clk_i (clk_i),
    .wr_i  (wr),
    .ra_i  (ra),
    .rb_i  (rb),
    .rda_o (rda),
    .rdb_o (rdb)
  );

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign s_new      = prod_q + {{(32-PosW){1'b0}}, p_q};
  assign inner      = w0_q[0] ^ (^(s_new & Parity3));
  assign rlane      = sfmt_recur(rda, rdb, c_q, dl_q);
  assign word       = rda[32*pos_q[1:0] +: 32];

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    p_d      = p_q;
    s_d      = s_q;
    w0_d     = w0_q;
    prod_d   = prod_q;
    pend_d   = pend_q;
    kind_d   = kind_q;
    crange_d = crange_q;
    cbase_d  = cbase_q;
    cshift_d = cshift_q;
    y_d      = y_q;
    b_d      = b_q;
    sh_d     = sh_q;
    rem_d    = rem_q;
    res_d    = res_q;
    lane_d   = lane_q;
    c_d      = c_q;
    dl_d     = dl_q;
    ov_d     = ov_q && out_stall_i;
    ovalue_d = ovalue_q;
    wr       = '0;
    ra       = pos_q[PosW-1:2];
    rb       = '0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          kind_d = in_kind_i;
          unique case (in_kind_i)
            KindSeed: begin
              s_d      = in_seed_value_i;
              w0_d     = in_seed_value_i;
              p_d      = PosW'(1);
              crange_d = '0;
              pend_d   = 1'b0;
              state_d  = StSeedMul;
            end
            KindWord: state_d = StWord;
            KindBound: begin
              if (in_range_limit_i <= 0) begin
                res_d   = '0;
                state_d = StEmit;
              end else if (in_range_limit_i != crange_q) begin
                crange_d = in_range_limit_i;
                cbase_d  = in_range_limit_i;
                cshift_d = '0;
                state_d  = StNorm;
              end else begin
                state_d = StWord;
              end
            end
            default: state_d = StIdle;
          endcase
        end
      end
      StNorm: begin
        if (cbase_q <= NormTop) begin
          cbase_d  = cbase_q << 1;
          cshift_d = cshift_q + 5'd1;
        end else begin
          state_d = StWord;
        end
      end
      StSeedMul: begin
        prod_d  = Mult * (s_q ^ (s_q >> 30));
        state_d = StSeedAdd;
      end
      StSeedAdd: begin
        s_d          = s_new;
        wr.addr      = p_q[PosW-1:2];
        wr.en[p_q[1:0]] = 1'b1;
        wr.data      = {4{s_new}};
        if (p_q == PosW'(3)) begin
          wr.en[0]      = 1'b1;
          wr.data[31:0] = inner ? w0_q : (w0_q ^ 32'd1);
        end
        if (p_q == PosW'(Words - 1)) begin
          pos_d   = PosW'(Words);
          state_d = pend_q ? StWord : StIdle;
        end else begin
          p_d     = p_q + PosW'(1);
          state_d = StSeedMul;
        end
      end
      StWord: begin
        if (pos_q == '0) begin
          s_d      = dseed_q;
          w0_d     = dseed_q;
          p_d      = PosW'(1);
          pend_d   = 1'b1;
          state_d  = StSeedMul;
        end else if (pos_q >= PosW'(Words)) begin
          state_d = StRegInit;
        end else begin
          state_d = StFetRd;
        end
      end
      StRegInit: begin
        ra      = LaneW'(Lanes - 2);
        rb      = LaneW'(Lanes - 1);
        state_d = StRegLoad;
      end
      StRegLoad: begin
        c_d     = rda;
        dl_d    = rdb;
        lane_d  = '0;
        state_d = StRegRd;
      end
      StRegRd: begin
        ra      = lane_q;
        rb      = (lane_q < LaneW'(Lanes - Pos1)) ? lane_q + LaneW'(Pos1)
                                                  : lane_q - LaneW'(Lanes - Pos1);
        state_d = StRegWr;
      end
      StRegWr: begin
        wr.en   = 4'hf;
        wr.addr = lane_q;
        wr.data = rlane;
        c_d     = dl_q;
        dl_d    = rlane;
        if (lane_q == LaneW'(Lanes - 1)) begin
          pos_d   = '0;
          state_d = StFetRd;
        end else begin
          lane_d  = lane_q + LaneW'(1);
          state_d = StRegRd;
        end
      end
      StFetRd: state_d = StFetUse;
      StFetUse: begin
        pos_d = pos_q + PosW'(1);
        if (kind_q == KindWord) begin
          res_d   = word;
          state_d = StEmit;
        end else begin
          y_d     = word >> 1;
          b_d     = cbase_q;
          sh_d    = cshift_q;
          state_d = StBdChk;
        end
      end
      StBdChk: begin
        if (y_q < b_q) begin
          res_d   = y_q >> sh_q;
          state_d = StEmit;
        end else begin
          y_d     = y_q - b_q;
          rem_d   = Half - b_q;
          state_d = StBdLoop;
        end
      end
      StBdLoop: begin
        state_d = (rem_q >= crange_q) ? StBdShr : StWord;
      end
      StBdShr: begin
        if (b_q > rem_q && sh_q != '0) begin
          b_d  = b_q >> 1;
          sh_d = sh_q - 5'd1;
        end else if (y_q < b_q) begin
          res_d   = y_q >> sh_q;
          state_d = StEmit;
        end else begin
          y_d     = y_q - b_q;
          rem_d   = rem_q - b_q;
          state_d = StBdLoop;
        end
      end
      StEmit: begin
        if (!ov_q || !out_stall_i) begin
          ov_d     = 1'b1;
          ovalue_d = res_q;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      dseed_q  <= 32'd5489;
      pos_q    <= '0;
      pend_q   <= 1'b0;
      crange_q <= '0;
      cbase_q  <= '0;
      cshift_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) begin
        dseed_q <= cfg_wdata_i;
      end
      pos_q    <= pos_d;
      pend_q   <= pend_d;
      crange_q <= crange_d;
      cbase_q  <= cbase_d;
      cshift_q <= cshift_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    s_q      <= s_d;
    w0_q     <= w0_d;
    prod_q   <= prod_d;
    kind_q   <= kind_d;
    y_q      <= y_d;
    b_q      <= b_d;
    sh_q     <= sh_d;
    rem_q    <= rem_d;
    res_q    <= res_d;
    lane_q   <= lane_d;
    c_q      <= c_d;
    dl_q     <= dl_d;
    ovalue_q <= ovalue_d;
  end

  assign out_valid_o = ov_q;
  assign out_value_o = ovalue_q;

  a_seed_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_kind_i == KindSeed) |=> (state_q == StSeedMul))
    else $error("seed request did not start seeding");
  a_fetch_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFetUse) |-> (pos_q < PosW'(Words)))
    else $error("word fetch past end of state");
  a_lane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRegWr) |-> (lane_q < LaneW'(Lanes)))
    else $error("lane index out of range");
  a_draw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StBdShr) |-> (y_q < Half))
    else $error("rejection value out of range");

endmodule
`default_nettype wire

/* bench/sfmt_bounded_random_generator_core_test.sv */
// Self-checking bench for the SFMT19937 bounded random generator core.
// Drives seed, word and bounded requests, predicts every value in the bench.
// Depends on sfmt_pkg and sfmt_bounded_random_generator_core.
module sfmt_bounded_random_generator_core_test;
  import sfmt_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seed;
    logic [31:0] range;
  } req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] in_kind_i = '0;
  logic [31:0] in_seed_value_i = '0;
  logic signed [31:0] in_range_limit_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [31:0] out_value_o;

  sfmt_bounded_random_generator_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_kind_i(in_kind_i),
    .in_seed_value_i(in_seed_value_i), .in_range_limit_i(in_range_limit_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_value_o(out_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // generator model state
  logic [31:0] gen_words [Words];
  logic [31:0] dflt_seed = 32'd5489;
  int unsigned rd_pos = 0;
  logic [31:0] c_range = '0, c_base = '0;
  int unsigned c_shift = 0;

  req_t pending_reqs[$];
  logic [31:0] expected_values[$];
  int mismatches = 0;
  bit quiet = 1'b0;
  int phase_n = 0;

  function automatic void seed_words(logic [31:0] s);
    logic [31:0] inner;
    gen_words[0] = s;
    for (int p = 1; p < Words; p++) begin
      s = Mult * (s ^ (s >> 30)) + p;
      gen_words[p] = s;
    end
    rd_pos = Words;
    c_range = '0;
    inner = (gen_words[0] & 32'd1) ^ (gen_words[3] & Parity3);
    if (!(^inner)) gen_words[0] = gen_words[0] ^ 32'd1;
  endfunction

  function automatic void regen_lanes();
    logic [127:0] a, b, c, d, r;
    c = {gen_words[619], gen_words[618], gen_words[617], gen_words[616]};
    d = {gen_words[623], gen_words[622], gen_words[621], gen_words[620]};
    for (int i = 0; i < Lanes; i++) begin
      int bl;
      bl = (i + Pos1) % Lanes;
      a = {gen_words[4*i+3], gen_words[4*i+2], gen_words[4*i+1], gen_words[4*i]};
      b = {gen_words[4*bl+3], gen_words[4*bl+2], gen_words[4*bl+1], gen_words[4*bl]};
      for (int k = 0; k < 4; k++) begin
        logic [31:0] m;
        m = (k == 0) ? Mask0 : (k == 1) ? Mask1 : (k == 2) ? Mask2 : Mask3;
        r[32*k +: 32] = a[32*k +: 32] ^ ((b[32*k +: 32] >> 11) & m) ^ (d[32*k +: 32] << 18);
      end
      r = r ^ (a << 8) ^ (c >> 8);
      for (int k = 0; k < 4; k++) gen_words[4*i+k] = r[32*k +: 32];
      c = d;
      d = r;
    end
    rd_pos = 0;
  endfunction

  function automatic logic [31:0] pull_word();
    logic [31:0] w;
    if (rd_pos == 0) seed_words(dflt_seed);
    if (rd_pos >= Words) regen_lanes();
    w = gen_words[rd_pos];
    rd_pos++;
    return w;
  endfunction

  function automatic logic [31:0] bounded_value(logic [31:0] range);
    logic [31:0] y, b, rem;
    int unsigned sh;
    if (range != c_range) begin
      c_range = range;
      c_base = range;
      c_shift = 0;
      while (c_base <= NormTop) begin
        c_base = c_base << 1;
        c_shift++;
      end
    end
    forever begin
      y = pull_word() >> 1;
      b = c_base;
      sh = c_shift & 31;
      if (y < b) return y >> sh;
      y -= b;
      rem = Half - b;
      while (rem >= range) begin
        while (b > rem && sh > 0) begin
          b = b >> 1;
          sh--;
        end
        if (y < b) return y >> sh;
        y -= b;
        rem -= b;
      end
    end
  endfunction

  function automatic void predict(req_t q);
    case (q.kind)
      KindSeed: seed_words(q.seed);
      KindWord: expected_values.push_back(pull_word());
      KindBound:
        if (q.range == 0 || q.range[31]) expected_values.push_back('0);
        else expected_values.push_back(bounded_value(q.range));
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      predict(pending_reqs.pop_front());
    end
    if (!in_valid_i || !in_stall_o) begin
      if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 24)) begin
        in_valid_i <= 1'b1;
        in_kind_i <= pending_reqs[0].kind;
        in_seed_value_i <= pending_reqs[0].seed;
        in_range_limit_i <= pending_reqs[0].range;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected value %h", out_value_o);
      end else begin
        logic [31:0] e;
        e = expected_values.pop_front();
        if (e !== out_value_o) begin
          mismatches++;
          if (mismatches <= 10) $display("value: expected %h got %h", e, out_value_o);
        end
      end
    end
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 24);
  end

  function automatic req_t rand_req();
    req_t q;
    int sel;
    sel = $urandom_range(99);
    q.seed = $urandom;
    q.range = $urandom;
    if (sel < 3) q.kind = KindSeed;
    else if (sel < 45) q.kind = KindWord;
    else if (sel < 98) q.kind = KindBound;
    else q.kind = 2'd3;
    case ($urandom_range(5))
      0: q.range = $urandom_range(16);
      1: q.range = 32'd1 << $urandom_range(31);
      2: q.range = (32'd1 << $urandom_range(31)) + 32'd1;
      3: q.range = $urandom_range(200, 1);
      default: ;
    endcase
    return q;
  endfunction

  task automatic drain();
    wait (pending_reqs.size() == 0 && expected_values.size() == 0);
    repeat (400) @(posedge clk_i);
    wait (!in_stall_o);
    @(posedge clk_i);
  endtask

  task automatic write_seed_cfg(logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    dflt_seed = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push(logic [1:0] k, logic [31:0] s, logic [31:0] r);
    req_t q;
    q.kind = k;
    q.seed = s;
    q.range = r;
    pending_reqs.push_back(q);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // draw before seed uses reset default
    push(KindWord, '0, '0);
    push(KindBound, '1, 32'd6);
    push(KindBound, '0, 32'd0);
    push(KindBound, '0, 32'h8000_0000);
    push(KindBound, '0, 32'hffff_ffff);
    push(KindBound, '0, 32'h7fff_ffff);
    push(KindBound, '0, 32'd1);
    push(KindBound, '0, 32'h4000_0001);
    push(KindBound, '0, 32'h4000_0000);
    push(2'd3, '1, '1);
    push(KindSeed, 32'd0, '0);
    push(KindWord, '0, '0);
    push(KindSeed, 32'hffff_ffff, '0);
    push(KindBound, '0, 32'd3);
    push(KindSeed, 32'h1234_5678, '0);
    for (int i = 0; i < 8; i++) push(KindWord, '0, '0);
    drain();
    foreach (pending_reqs[i]) ;
    for (phase_n = 0; phase_n < 4; phase_n++) begin
      rst_ni <= rst_ni;
      write_seed_cfg(phase_n == 0 ? 32'd0 : phase_n == 1 ? 32'hffff_ffff : $urandom);
      if (phase_n == 0) push(KindWord, '0, '0);
      quiet = (phase_n == 2);
      for (int i = 0; i < 375; i++) pending_reqs.push_back(rand_req());
      drain();
    end
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #50000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/sfmt_pkg.sv
hw/rtl/sfmt_store.sv
hw/rtl/sfmt_bounded_random_generator_core.sv
bench/sfmt_bounded_random_generator_core_test.sv
